FILE: hdl/timed_value_history_store_assert.svh
// Assertion macros for the timed value history store.
`ifndef TIMED_VALUE_HISTORY_STORE_ASSERT_SVH
`define TIMED_VALUE_HISTORY_STORE_ASSERT_SVH
`ifndef SYNTH
`define TVHS_ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");
`define TVHS_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");
`else
`define TVHS_ASSERT_IMPLY(label, clk, rst_n, ante, cons)
`define TVHS_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif
`endif

FILE: hdl/tvhs_pkg.sv
// Shared types, codes and defaults of the timed value history store.
package tvhs_pkg;

    localparam int DEPTH_DEF     = 16;
    localparam int TIME_BITS_DEF = 48;
    localparam int VALUE_W       = 64;
    localparam int ERR_W         = 3;
    localparam int MODE_W        = 2;
    localparam int APB_AW        = 3;
    localparam int APB_DW        = 32;

    localparam logic CFG_IDX_TRACKING = 1'b0;

    typedef enum logic [MODE_W-1:0] {
        MODE_APPEND = 2'd0,
        MODE_TRIM   = 2'd1,
        MODE_QUERY  = 2'd2,
        MODE_NONE   = 2'd3
    } t_mode;

    typedef enum logic [ERR_W-1:0] {
        ERR_OK    = 3'd0,
        ERR_EMPTY = 3'd1,
        ERR_EARLY = 3'd2,
        ERR_ORDER = 3'd3,
        ERR_FULL  = 3'd4
    } t_err;

    typedef enum logic [2:0] {
        S_IDLE,
        S_CHECK,
        S_TRIM,
        S_RD,
        S_CMP,
        S_VAL,
        S_DONE
    } t_state;

    typedef struct packed {
        logic latch;
        logic err_en;
        t_err err;
        logic app_write;
        logic keep_newest;
        logic idx_init;
        logic idx_inc;
        logic rd_time;
        logic rd_val_newest;
        logic rd_val_prev;
        logic cap_val;
        logic trim_eq;
        logic trim_retime;
    } t_cmd;

    typedef struct packed {
        t_mode mode;
        logic  empty;
        logic  full;
        logic  before_newest;
        logic  before_oldest;
        logic  at_or_before_oldest;
        logic  past_newest;
        logic  rd_gt;
        logic  rd_eq;
        logic  tracking;
    } t_sts;

endpackage

FILE: hdl/tvhs_ram.sv
// Generic simple dual-port RAM with registered read data.
module tvhs_ram import tvhs_pkg::*; #(
    parameter int WIDTH = VALUE_W,
    parameter int DEPTH = DEPTH_DEF
) (
    input  logic                     i_clk,
    input  logic                     i_wr_en,
    input  logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]         i_wr_data,
    input  logic                     i_rd_en,
    input  logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic [WIDTH-1:0]         o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

FILE: hdl/tvhs_ctrl.sv
// Controller state machine sequencing append, trim and query transactions.
module tvhs_ctrl import tvhs_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_start,
    input  t_sts i_sts,
    output t_cmd o_cmd,
    output logic o_busy,
    output logic o_valid
);

    t_state r_state;
    t_state n_state;
    logic   w_stop;

    assign w_stop = (i_sts.mode == MODE_QUERY) ? i_sts.rd_gt : (i_sts.rd_gt || i_sts.rd_eq);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (i_start) begin
                    n_state = S_CHECK;
                end
            end
            S_CHECK: begin
                case (i_sts.mode)
                    MODE_APPEND: begin
                        if ((!i_sts.empty && i_sts.before_newest) || i_sts.full) begin
                            n_state = S_DONE;
                        end else if (i_sts.tracking) begin
                            n_state = S_DONE;
                        end else begin
                            n_state = S_TRIM;
                        end
                    end
                    MODE_TRIM: begin
                        n_state = i_sts.empty ? S_DONE : S_TRIM;
                    end
                    MODE_QUERY: begin
                        if (i_sts.empty || i_sts.before_oldest) begin
                            n_state = S_DONE;
                        end else if (!i_sts.before_newest) begin
                            n_state = S_VAL;
                        end else begin
                            n_state = S_RD;
                        end
                    end
                    default: n_state = S_DONE;
                endcase
            end
            S_TRIM: begin
                if (i_sts.at_or_before_oldest || i_sts.past_newest) begin
                    n_state = S_DONE;
                end else begin
                    n_state = S_RD;
                end
            end
            S_RD:   n_state = S_CMP;
            S_CMP: begin
                if (w_stop) begin
                    n_state = (i_sts.mode == MODE_QUERY) ? S_VAL : S_DONE;
                end else begin
                    n_state = S_RD;
                end
            end
            S_VAL:  n_state = S_DONE;
            S_DONE: n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    always_comb begin
        o_cmd   = '0;
        o_busy  = 1'b1;
        o_valid = 1'b0;
        case (r_state)
            S_IDLE: begin
                o_busy    = 1'b0;
                o_cmd.latch = i_start;
            end
            S_CHECK: begin
                case (i_sts.mode)
                    MODE_APPEND: begin
                        if (!i_sts.empty && i_sts.before_newest) begin
                            o_cmd.err_en = 1'b1;
                            o_cmd.err    = ERR_ORDER;
                        end else if (i_sts.full) begin
                            o_cmd.err_en = 1'b1;
                            o_cmd.err    = ERR_FULL;
                        end else begin
                            o_cmd.app_write = 1'b1;
                        end
                    end
                    MODE_TRIM: begin
                        if (i_sts.empty) begin
                            o_cmd.err_en = 1'b1;
                            o_cmd.err    = ERR_EMPTY;
                        end
                    end
                    MODE_QUERY: begin
                        if (i_sts.empty) begin
                            o_cmd.err_en = 1'b1;
                            o_cmd.err    = ERR_EMPTY;
                        end else if (i_sts.before_oldest) begin
                            o_cmd.err_en = 1'b1;
                            o_cmd.err    = ERR_EARLY;
                        end else if (!i_sts.before_newest) begin
                            o_cmd.rd_val_newest = 1'b1;
                        end else begin
                            o_cmd.idx_init = 1'b1;
                        end
                    end
                    default: o_cmd = '0;
                endcase
            end
            S_TRIM: begin
                if (i_sts.at_or_before_oldest) begin
                    o_cmd = '0;
                end else if (i_sts.past_newest) begin
                    o_cmd.keep_newest = 1'b1;
                end else begin
                    o_cmd.idx_init = 1'b1;
                end
            end
            S_RD: o_cmd.rd_time = 1'b1;
            S_CMP: begin
                if (!w_stop) begin
                    o_cmd.idx_inc = 1'b1;
                end else if (i_sts.mode == MODE_QUERY) begin
                    o_cmd.rd_val_prev = 1'b1;
                end else if (i_sts.rd_eq) begin
                    o_cmd.trim_eq = 1'b1;
                end else begin
                    o_cmd.trim_retime = 1'b1;
                end
            end
            S_VAL:  o_cmd.cap_val = 1'b1;
            S_DONE: o_valid = 1'b1;
            default: o_busy = 1'b1;
        endcase
    end

endmodule

FILE: hdl/tvhs_dpath.sv
// Datapath: ring pointers, entry memories, comparators and result registers.
module tvhs_dpath import tvhs_pkg::*; #(
    parameter int DEPTH     = DEPTH_DEF,
    parameter int TIME_BITS = TIME_BITS_DEF
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic [MODE_W-1:0]          i_mode,
    input  logic [TIME_BITS-1:0]       i_stamp,
    input  logic [VALUE_W-1:0]         i_entry_value,
    input  logic                       i_tracking_on,
    input  t_cmd                       i_cmd,
    output t_sts                       o_sts,
    output logic [VALUE_W-1:0]         o_read_value,
    output logic [ERR_W-1:0]           o_error_code,
    output logic [$clog2(DEPTH+1)-1:0] o_entry_count
);

    localparam int SLOT_W = $clog2(DEPTH);
    localparam int CNT_W  = $clog2(DEPTH + 1);
    localparam logic [CNT_W:0]   DEPTH_SUM = (CNT_W + 1)'(DEPTH);
    localparam logic [CNT_W-1:0] CNT_ONE   = CNT_W'(1);
    localparam logic [CNT_W-1:0] CNT_FULL  = CNT_W'(DEPTH);

    function automatic logic [SLOT_W-1:0] slot_at(input logic [SLOT_W-1:0] base,
                                                  input logic [CNT_W-1:0]  off);
        logic [CNT_W:0] sum;
        sum = {{(CNT_W + 1 - SLOT_W){1'b0}}, base} + {1'b0, off};
        if (sum >= DEPTH_SUM) begin
            sum = sum - DEPTH_SUM;
        end
        return sum[SLOT_W-1:0];
    endfunction

    t_mode                r_mode;
    logic [TIME_BITS-1:0] r_stamp;
    logic [VALUE_W-1:0]   r_value;
    logic [SLOT_W-1:0]    r_oldest_slot;
    logic [SLOT_W-1:0]    n_oldest_slot;
    logic [CNT_W-1:0]     r_count;
    logic [CNT_W-1:0]     n_count;
    logic [TIME_BITS-1:0] r_oldest_time;
    logic [TIME_BITS-1:0] n_oldest_time;
    logic [TIME_BITS-1:0] r_newest_time;
    logic [CNT_W-1:0]     r_idx;
    logic [VALUE_W-1:0]   r_read_value;
    t_err                 r_err;

    logic [SLOT_W-1:0]    w_slot_cnt;
    logic [SLOT_W-1:0]    w_slot_last;
    logic [SLOT_W-1:0]    w_slot_idx;
    logic [SLOT_W-1:0]    w_slot_prev;
    logic [CNT_W-1:0]     w_idx_prev;
    logic [TIME_BITS-1:0] w_rd_time;
    logic [VALUE_W-1:0]   w_rd_value;
    logic                 w_time_we;
    logic [SLOT_W-1:0]    w_time_waddr;
    logic                 w_val_re;
    logic [SLOT_W-1:0]    w_val_raddr;

    assign w_idx_prev  = r_idx - CNT_ONE;
    assign w_slot_cnt  = slot_at(r_oldest_slot, r_count);
    assign w_slot_last = slot_at(r_oldest_slot, r_count - CNT_ONE);
    assign w_slot_idx  = slot_at(r_oldest_slot, r_idx);
    assign w_slot_prev = slot_at(r_oldest_slot, w_idx_prev);

    assign w_time_we    = i_cmd.app_write || i_cmd.trim_retime;
    assign w_time_waddr = i_cmd.app_write ? w_slot_cnt : w_slot_prev;
    assign w_val_re     = i_cmd.rd_val_newest || i_cmd.rd_val_prev;
    assign w_val_raddr  = i_cmd.rd_val_newest ? w_slot_last : w_slot_prev;

    tvhs_ram #(
        .WIDTH (TIME_BITS),
        .DEPTH (DEPTH)
    ) u_time_ram (
        .i_clk     (i_clk),
        .i_wr_en   (w_time_we),
        .i_wr_addr (w_time_waddr),
        .i_wr_data (r_stamp),
        .i_rd_en   (i_cmd.rd_time),
        .i_rd_addr (w_slot_idx),
        .o_rd_data (w_rd_time)
    );

    tvhs_ram #(
        .WIDTH (VALUE_W),
        .DEPTH (DEPTH)
    ) u_value_ram (
        .i_clk     (i_clk),
        .i_wr_en   (i_cmd.app_write),
        .i_wr_addr (w_slot_cnt),
        .i_wr_data (r_value),
        .i_rd_en   (w_val_re),
        .i_rd_addr (w_val_raddr),
        .o_rd_data (w_rd_value)
    );

    always_comb begin
        n_oldest_slot = r_oldest_slot;
        n_count       = r_count;
        n_oldest_time = r_oldest_time;
        if (i_cmd.app_write) begin
            n_count = r_count + CNT_ONE;
            if (r_count == '0) begin
                n_oldest_time = r_stamp;
            end
        end else if (i_cmd.keep_newest) begin
            n_oldest_slot = w_slot_last;
            n_count       = CNT_ONE;
            n_oldest_time = r_newest_time;
        end else if (i_cmd.trim_eq) begin
            n_oldest_slot = w_slot_idx;
            n_count       = r_count - r_idx;
            n_oldest_time = r_stamp;
        end else if (i_cmd.trim_retime) begin
            n_oldest_slot = w_slot_prev;
            n_count       = r_count - w_idx_prev;
            n_oldest_time = r_stamp;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_oldest_slot <= '0;
            r_count       <= '0;
        end else begin
            r_oldest_slot <= n_oldest_slot;
            r_count       <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        r_oldest_time <= n_oldest_time;
        if (i_cmd.app_write) begin
            r_newest_time <= r_stamp;
        end
        if (i_cmd.latch) begin
            r_mode       <= t_mode'(i_mode);
            r_stamp      <= i_stamp;
            r_value      <= i_entry_value;
            r_read_value <= '0;
            r_err        <= ERR_OK;
        end
        if (i_cmd.err_en) begin
            r_err <= i_cmd.err;
        end
        if (i_cmd.cap_val) begin
            r_read_value <= w_rd_value;
        end
        if (i_cmd.idx_init) begin
            r_idx <= CNT_ONE;
        end else if (i_cmd.idx_inc) begin
            r_idx <= r_idx + CNT_ONE;
        end
    end

    always_comb begin
        o_sts.mode                = r_mode;
        o_sts.empty               = (r_count == '0);
        o_sts.full                = (r_count == CNT_FULL);
        o_sts.before_newest       = (r_stamp < r_newest_time);
        o_sts.before_oldest       = (r_stamp < r_oldest_time);
        o_sts.at_or_before_oldest = (r_stamp <= r_oldest_time);
        o_sts.past_newest         = (r_stamp > r_newest_time);
        o_sts.rd_gt               = (w_rd_time > r_stamp);
        o_sts.rd_eq               = (w_rd_time == r_stamp);
        o_sts.tracking            = i_tracking_on;
    end

    assign o_read_value  = r_read_value;
    assign o_error_code  = r_err;
    assign o_entry_count = r_count;

endmodule

FILE: hdl/timed_value_history_store.sv
// Timed value history store: a time-ordered ring of (time, value) entries.
//
// A transaction is taken at the clock edge where start is high and busy is
// low; i_mode selects append, trim or query, i_stamp gives the time and
// i_entry_value the word stored on append. Each transaction yields exactly one
// result on o_read_value, o_error_code and o_entry_count, shown for a single
// cycle while o_valid is high; the receiver cannot stall it. Busy stays high
// from acceptance until the result cycle has ended.
// A short transaction (append with history kept, errors, unused mode) goes
// from the check state straight to done; otherwise a scan may read up to
// DEPTH-1 stored times from the time RAM, one per read/compare state pair:
// address in the read state, registered data compared in the next. A query
// that hits the newest entry or a trim past it skips the scan.
// The APB port holds tracking_on at byte address 0 (1 keeps history, 0 trims
// to each appended time); write it only while busy is low.
// Synchronous reset empties the store and clears tracking_on; the entry RAMs
// are not cleared, since no entry is read before it is written.
module timed_value_history_store import tvhs_pkg::*; #(
    parameter int DEPTH     = DEPTH_DEF,
    parameter int TIME_BITS = TIME_BITS_DEF
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       start,
    output logic                       busy,
    input  logic [MODE_W-1:0]          i_mode,
    input  logic [TIME_BITS-1:0]       i_stamp,
    input  logic [VALUE_W-1:0]         i_entry_value,
    output logic                       o_valid,
    output logic [VALUE_W-1:0]         o_read_value,
    output logic [ERR_W-1:0]           o_error_code,
    output logic [$clog2(DEPTH+1)-1:0] o_entry_count,
    input  logic                       psel,
    input  logic                       penable,
    input  logic                       pwrite,
    input  logic [APB_AW-1:0]          paddr,
    input  logic [APB_DW-1:0]          pwdata,
    output logic [APB_DW-1:0]          prdata,
    output logic                       pready
);

    t_cmd w_cmd;
    t_sts w_sts;
    logic r_tracking_on;
    logic w_cfg_wr;

    assign pready   = 1'b1;
    assign w_cfg_wr = psel && penable && pwrite && pready && (paddr[2] == CFG_IDX_TRACKING);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tracking_on <= 1'b0;
        end else if (w_cfg_wr) begin
            r_tracking_on <= pwdata[0];
        end
    end

    assign prdata = (paddr[2] == CFG_IDX_TRACKING) ? {{(APB_DW - 1){1'b0}}, r_tracking_on}
                                                   : '0;

    tvhs_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (start),
        .i_sts   (w_sts),
        .o_cmd   (w_cmd),
        .o_busy  (busy),
        .o_valid (o_valid)
    );

    tvhs_dpath #(
        .DEPTH     (DEPTH),
        .TIME_BITS (TIME_BITS)
    ) u_dpath (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_mode        (i_mode),
        .i_stamp       (i_stamp),
        .i_entry_value (i_entry_value),
        .i_tracking_on (r_tracking_on),
        .i_cmd         (w_cmd),
        .o_sts         (w_sts),
        .o_read_value  (o_read_value),
        .o_error_code  (o_error_code),
        .o_entry_count (o_entry_count)
    );

`include "timed_value_history_store_assert.svh"

    `TVHS_ASSERT_IMPLY(a_count_bound, i_clk, i_rst_n, o_valid, o_entry_count <= ($clog2(DEPTH+1))'(DEPTH))
    `TVHS_ASSERT_NEXT(a_accept_busy, i_clk, i_rst_n, start && !busy, busy)
    `TVHS_ASSERT_NEXT(a_result_frees, i_clk, i_rst_n, o_valid, !busy && !o_valid)
    `TVHS_ASSERT_IMPLY(a_err_no_value, i_clk, i_rst_n, o_valid && (o_error_code != ERR_OK), o_read_value == '0)

endmodule
